// ----- design/detu_pkg.sv -----
// Package for the delayed event timer table: request, mode and result codes,
// the slot entry layout kept in the slot memory, and the result beat layout.
// No dependencies.
package detu_pkg;

   typedef enum logic [1:0] {
      REQ_SCHED  = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_TICK   = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      MODE_ALWAYS  = 2'd0,
      MODE_COVER   = 2'd1,
      MODE_NEAREST = 2'd2,
      MODE_INVALID = 2'd3
   } sched_mode_type;

   typedef enum logic [2:0] {
      KIND_FIRED   = 3'd0,
      KIND_SCHED   = 3'd1,
      KIND_DELETED = 3'd2,
      KIND_FULL    = 3'd3,
      KIND_BADMODE = 3'd4
   } result_kind_type;

   localparam logic [4:0] COUNT_MAX = 5'd31;

   typedef struct packed {
      logic [7:0]  evt_id;
      logic [31:0] arg;
      logic [31:0] tag;
      logic [31:0] remaining;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      evt_id;
      logic [31:0]     arg;
      logic [31:0]     tag;
      logic [4:0]      removed;
   } result_type;

endpackage

// ----- design/detu_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module detu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

// ----- design/delayed_event_timer_table_unit.sv -----
// Top level of the delayed event timer table.
// Depends on detu_pkg and detu_ram (slot memory).
//
// Usage: requests arrive on the req_ stream, one beat per request; req_tuser
// carries the request kind (schedule, delete, tick). Results leave on the
// rsp_ stream; rsp_tuser carries the result kind and rsp_tlast marks the
// final result beat caused by a request. A quiet tick and an unknown request
// kind give no result beat.
// Flow: a schedule that is rejected, fires at once or uses mode always skips
// the walk. A delete, a cover or nearest schedule and a tick walk the slot
// memory one slot per cycle through its single read port, save where a tick
// walk stalls on the receiver. A new request is taken once the previous one
// is finished, also while its last result beat still waits. Reset frees every
// slot at once (busy bits are flip-flops); the slot memory itself is not
// cleared. When the receiver stalls, a tick walk pauses on the slot that
// fires while two earlier results are still waiting.
module delayed_event_timer_table_unit #(
   parameter int SLOT_COUNT = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // delay_ms [31:0], event_id [39:32], event_arg [71:40], event_tag [103:72],
   // sched_mode [105:104], zero fill [111:106]
   input  logic [111:0] req_tdata,
   // req_type [1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fired_event [7:0], fired_arg [39:8], fired_tag [71:40],
   // removed_count [76:72], zero fill [79:77]
   output logic [79:0]  rsp_tdata,
   // result_kind [2:0]
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                op_ff, op_in;
   logic [1:0]                mode_ff, mode_in;
   logic [7:0]                ev_ff, ev_in;
   logic [31:0]               arg_ff, arg_in;
   logic [31:0]               tag_ff, tag_in;
   logic [31:0]               min_ff, min_in;
   logic [IDX_W-1:0]          free_ff, free_in;
   logic [4:0]                count_ff, count_in;
   logic [CNT_W-1:0]          rd_cnt_ff, rd_cnt_in;
   logic                      proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]          proc_idx_ff, proc_idx_in;
   logic [SLOT_COUNT-1:0]     busy_ff, busy_in;
   logic                      hold_valid_ff, hold_valid_in;
   detu_pkg::result_type      hold_ff, hold_in;
   logic                      out_valid_ff, out_valid_in;
   detu_pkg::result_type      out_ff, out_in;
   logic                      out_last_ff, out_last_in;

   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   logic [detu_pkg::ENTRY_W-1:0]  ram_wr_data;
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   logic [detu_pkg::ENTRY_W-1:0]  ram_rd_data;

   detu_pkg::slot_entry_type  rd_entry;
   detu_pkg::slot_entry_type  wr_entry;
   detu_pkg::result_type      new_result;

   logic [31:0]      req_delay;
   logic [7:0]       req_ev;
   logic [31:0]      req_arg;
   logic [31:0]      req_tag;
   logic [1:0]       req_mode;
   logic [IDX_W-1:0] free_idx;
   logic             any_free;
   logic [31:0]      rem_dec;
   logic             slot_fires;
   logic             out_free;
   logic             stall;

   assign req_delay = req_tdata[31:0];
   assign req_ev    = req_tdata[39:32];
   assign req_arg   = req_tdata[71:40];
   assign req_tag   = req_tdata[103:72];
   assign req_mode  = req_tdata[105:104];

   detu_ram #(
      .WIDTH (detu_pkg::ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = ram_rd_data;

   // Lowest free slot, taken before anything is removed.
   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx = IDX_W'(i);
            any_free = 1'b1;
         end
      end
   end

   assign rem_dec    = (rd_entry.remaining != 32'd0) ? rd_entry.remaining - 32'd1 : 32'd0;
   assign slot_fires = busy_ff[proc_idx_ff] && (rem_dec == 32'd0);
   assign out_free   = !out_valid_ff || rsp_tready;

   // A firing slot must push the held result out; wait while the output is full and not taken.
   assign stall = (state_ff == S_WALK) && proc_valid_ff &&
                  (op_ff == detu_pkg::REQ_TICK) && slot_fires &&
                  hold_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      mode_in       = mode_ff;
      ev_in         = ev_ff;
      arg_in        = arg_ff;
      tag_in        = tag_ff;
      min_in        = min_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      rd_cnt_in     = rd_cnt_ff;
      proc_valid_in = proc_valid_ff;
      proc_idx_in   = proc_idx_ff;
      busy_in       = busy_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = proc_idx_ff;
      wr_entry    = rd_entry;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_cnt_ff[IDX_W-1:0];

      new_result.kind    = detu_pkg::KIND_SCHED;
      new_result.evt_id  = req_ev;
      new_result.arg     = req_arg;
      new_result.tag     = req_tag;
      new_result.removed = 5'd0;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               mode_in   = req_mode;
               ev_in     = req_ev;
               arg_in    = req_arg;
               tag_in    = req_tag;
               min_in    = req_delay;
               free_in   = free_idx;
               count_in  = 5'd0;
               rd_cnt_in = '0;
               unique case (req_tuser)
                  detu_pkg::REQ_SCHED: begin
                     if (!any_free) begin
                        new_result.kind = detu_pkg::KIND_FULL;
                        hold_in         = new_result;
                        hold_valid_in   = 1'b1;
                        state_in        = S_FINISH;
                     end else if (req_delay == 32'd0) begin
                        new_result.kind = detu_pkg::KIND_FIRED;
                        hold_in         = new_result;
                        hold_valid_in   = 1'b1;
                        state_in        = S_FINISH;
                     end else if (req_mode == detu_pkg::MODE_INVALID) begin
                        new_result.kind = detu_pkg::KIND_BADMODE;
                        hold_in         = new_result;
                        hold_valid_in   = 1'b1;
                        state_in        = S_FINISH;
                     end else if (req_mode == detu_pkg::MODE_ALWAYS) begin
                        wr_entry.evt_id    = req_ev;
                        wr_entry.arg       = req_arg;
                        wr_entry.tag       = req_tag;
                        wr_entry.remaining = req_delay;
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = free_idx;
                        busy_in[free_idx]  = 1'b1;
                        hold_in            = new_result;
                        hold_valid_in      = 1'b1;
                        state_in           = S_FINISH;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  detu_pkg::REQ_DELETE: state_in = S_WALK;
                  detu_pkg::REQ_TICK:   state_in = S_WALK;
                  default:              state_in = S_IDLE;
               endcase
            end
         end

         S_WALK: begin
            if (!stall) begin
               if (rd_cnt_ff < CNT_W'(SLOT_COUNT)) begin
                  ram_rd_en     = 1'b1;
                  rd_cnt_in     = rd_cnt_ff + 1'b1;
                  proc_valid_in = 1'b1;
                  proc_idx_in   = rd_cnt_ff[IDX_W-1:0];
               end else begin
                  proc_valid_in = 1'b0;
               end
            end

            if (proc_valid_ff && !stall) begin
               if (op_ff == detu_pkg::REQ_TICK) begin
                  if (busy_ff[proc_idx_ff]) begin
                     if (slot_fires) begin
                        busy_in[proc_idx_ff] = 1'b0;
                        if (hold_valid_ff) begin
                           out_in       = hold_ff;
                           out_last_in  = 1'b0;
                           out_valid_in = 1'b1;
                        end
                        hold_in.kind    = detu_pkg::KIND_FIRED;
                        hold_in.evt_id  = rd_entry.evt_id;
                        hold_in.arg     = rd_entry.arg;
                        hold_in.tag     = rd_entry.tag;
                        hold_in.removed = 5'd0;
                        hold_valid_in   = 1'b1;
                     end else begin
                        wr_entry.remaining = rem_dec;
                        ram_wr_en          = 1'b1;
                     end
                  end
               end else if (busy_ff[proc_idx_ff] && (rd_entry.evt_id == ev_ff)) begin
                  busy_in[proc_idx_ff] = 1'b0;
                  if (count_ff != detu_pkg::COUNT_MAX) begin
                     count_in = count_ff + 5'd1;
                  end
                  if ((mode_ff == detu_pkg::MODE_NEAREST) && (rd_entry.remaining < min_ff)) begin
                     min_in = rd_entry.remaining;
                  end
               end
            end

            if ((rd_cnt_ff == CNT_W'(SLOT_COUNT)) && !proc_valid_ff) begin
               state_in = S_FINISH;
               if (op_ff == detu_pkg::REQ_SCHED) begin
                  wr_entry.evt_id    = ev_ff;
                  wr_entry.arg       = arg_ff;
                  wr_entry.tag       = tag_ff;
                  wr_entry.remaining = min_ff;
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = free_ff;
                  busy_in[free_ff]   = 1'b1;
                  hold_in.kind       = detu_pkg::KIND_SCHED;
                  hold_in.evt_id     = ev_ff;
                  hold_in.arg        = arg_ff;
                  hold_in.tag        = tag_ff;
                  hold_in.removed    = count_ff;
                  hold_valid_in      = 1'b1;
               end else if (op_ff == detu_pkg::REQ_DELETE) begin
                  hold_in.kind    = detu_pkg::KIND_DELETED;
                  hold_in.evt_id  = ev_ff;
                  hold_in.arg     = 32'd0;
                  hold_in.tag     = 32'd0;
                  hold_in.removed = count_ff;
                  hold_valid_in   = 1'b1;
               end
            end
         end

         S_FINISH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_in        = hold_ff;
               out_last_in   = 1'b1;
               out_valid_in  = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      ram_wr_data = wr_entry;
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      mode_ff     <= mode_in;
      ev_ff       <= ev_in;
      arg_ff      <= arg_in;
      tag_ff      <= tag_in;
      min_ff      <= min_in;
      free_ff     <= free_in;
      count_ff    <= count_in;
      proc_idx_ff <= proc_idx_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_cnt_ff     <= '0;
         proc_valid_ff <= 1'b0;
         busy_ff       <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_cnt_ff     <= rd_cnt_in;
         proc_valid_ff <= proc_valid_in;
         busy_ff       <= busy_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {3'b000, out_ff.removed, out_ff.tag, out_ff.arg, out_ff.evt_id};
   assign rsp_tlast  = out_last_ff;

   // Every result of a request has left the hold stage before the next one is taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_valid_ff)
      else $error("held result still pending while idle");

   // The walk stage only carries a slot during a walk.
   assert property (@(posedge clock) disable iff (reset)
      proc_valid_ff |-> (state_ff == S_WALK))
      else $error("slot in process outside a walk");

   // A write-back never lands on the slot being read in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("slot memory read and write collide");

   // The read counter never runs past the table.
   assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= CNT_W'(SLOT_COUNT))
      else $error("walk counter past the last slot");

endmodule

// ----- verif/delayed_event_timer_table_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for delayed_event_timer_table_unit: a directed table followed
// by shaped random traffic, checked against a slot table kept inside the bench or typed beats.
// Depends on detu_pkg and the RTL of the block.
module delayed_event_timer_table_unit_tb;

   localparam int SLOTS        = 16;
   localparam int RANDOM_ITEMS = 205;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 2 * (SLOTS + 4);
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   // Where the expected beats of a request come from.
   typedef enum {ANS_MODEL, ANS_NONE, ANS_TYPED} answer_src_type;

   typedef struct packed {
      detu_pkg::result_kind_type kind;
      logic [7:0]                evt;
      logic [31:0]               arg;
      logic [31:0]               tag;
      logic [4:0]                removed;
      logic                      last;
   } timer_beat_type;

   typedef struct {
      logic [1:0]     rtype;
      logic [31:0]    delay;
      logic [7:0]     id;
      logic [31:0]    arg;
      logic [31:0]    tag;
      logic [1:0]     mode;
      answer_src_type src;
      timer_beat_type beat;
   } timer_req_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // delay_ms, event_id, event_arg, event_tag, sched_mode, zero fill
   logic [111:0] req_tdata  = '0;
   // req_type
   logic [1:0]   req_tuser  = detu_pkg::REQ_SCHED;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // fired_event, fired_arg, fired_tag, removed_count, zero fill
   logic [79:0]  rsp_tdata;
   // result_kind
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   // Slot table of the bench.
   logic        slot_live [SLOTS] = '{default: 1'b0};
   logic [7:0]  slot_evt  [SLOTS];
   logic [31:0] slot_arg  [SLOTS];
   logic [31:0] slot_tag  [SLOTS];
   logic [31:0] slot_left [SLOTS];

   timer_beat_type step_beats[$];
   timer_beat_type awaited_beats[$];
   timer_req_type  directed_rows[$];
   answer_src_type cur_src   = ANS_NONE;
   timer_beat_type cur_beat  = '0;
   int             burst_left = 1;
   int             error_count = 0;
   int             kind_hits [5] = '{default: 0};
   bit             hold_armed = 1'b0;
   bit             hold_done  = 1'b0;

   delayed_event_timer_table_unit #(
      .SLOT_COUNT(SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic timer_beat_type make_beat(detu_pkg::result_kind_type kind,
         logic [7:0] evt, logic [31:0] arg, logic [31:0] tag, int removed);
      timer_beat_type b;
      b.kind    = kind;
      b.evt     = evt;
      b.arg     = arg;
      b.tag     = tag;
      b.removed = (removed > detu_pkg::COUNT_MAX) ? detu_pkg::COUNT_MAX : removed[4:0];
      b.last    = 1'b0;
      return b;
   endfunction

   function automatic timer_req_type timer_row(logic [1:0] rtype, logic [31:0] delay,
         logic [7:0] id, logic [31:0] arg, logic [31:0] tag, logic [1:0] mode,
         answer_src_type src, detu_pkg::result_kind_type kind = detu_pkg::KIND_FIRED,
         int removed = 0);
      timer_req_type r;
      r.rtype = rtype;
      r.delay = delay;
      r.id    = id;
      r.arg   = arg;
      r.tag   = tag;
      r.mode  = mode;
      r.src   = src;
      // A delete answers with empty arguments.
      if (kind == detu_pkg::KIND_DELETED) begin
         r.beat = make_beat(kind, id, '0, '0, removed);
      end else begin
         r.beat = make_beat(kind, id, arg, tag, removed);
      end
      r.beat.last = 1'b1;
      return r;
   endfunction

   function automatic string beat_text(timer_beat_type b);
      return $sformatf("kind %0d event %0d arg %h tag %h removed %0d last %0b",
                       b.kind, b.evt, b.arg, b.tag, b.removed, b.last);
   endfunction

   // Applies one request to the slot table and leaves its result beats in step_beats.
   function automatic void predict_timer_request(timer_req_type r);
      int             free_slot;
      int             removed;
      logic [31:0]    delay;
      timer_beat_type b;
      free_slot = -1;
      removed   = 0;
      delay     = r.delay;
      step_beats.delete();
      case (r.rtype)
         detu_pkg::REQ_SCHED: begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!slot_live[i]) free_slot = i;
            end
            if (free_slot < 0) begin
               step_beats.push_back(make_beat(detu_pkg::KIND_FULL, r.id, r.arg, r.tag, 0));
            end else if (delay == 0) begin
               step_beats.push_back(make_beat(detu_pkg::KIND_FIRED, r.id, r.arg, r.tag, 0));
            end else if (r.mode == detu_pkg::MODE_INVALID) begin
               step_beats.push_back(make_beat(detu_pkg::KIND_BADMODE, r.id, r.arg, r.tag,
                                              0));
            end else begin
               // The free slot is chosen before older copies of the event are dropped;
               // nearest keeps the earliest expiry among them.
               if (r.mode != detu_pkg::MODE_ALWAYS) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (slot_live[i] && slot_evt[i] == r.id) begin
                        if (r.mode == detu_pkg::MODE_NEAREST && slot_left[i] < delay) begin
                           delay = slot_left[i];
                        end
                        slot_live[i] = 1'b0;
                        removed++;
                     end
                  end
               end
               slot_live[free_slot] = 1'b1;
               slot_evt[free_slot]  = r.id;
               slot_arg[free_slot]  = r.arg;
               slot_tag[free_slot]  = r.tag;
               slot_left[free_slot] = delay;
               step_beats.push_back(make_beat(detu_pkg::KIND_SCHED, r.id, r.arg, r.tag,
                                              removed));
            end
         end
         detu_pkg::REQ_DELETE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_live[i] && slot_evt[i] == r.id) begin
                  slot_live[i] = 1'b0;
                  removed++;
               end
            end
            step_beats.push_back(make_beat(detu_pkg::KIND_DELETED, r.id, '0, '0, removed));
         end
         detu_pkg::REQ_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_live[i]) begin
                  if (slot_left[i] != 0) slot_left[i]--;
                  if (slot_left[i] == 0) begin
                     slot_live[i] = 1'b0;
                     step_beats.push_back(make_beat(detu_pkg::KIND_FIRED, slot_evt[i],
                                                    slot_arg[i], slot_tag[i], 0));
                  end
               end
            end
         end
         default: ;
      endcase
      if (step_beats.size() > 0) begin
         b = step_beats.pop_back();
         b.last = 1'b1;
         step_beats.push_back(b);
      end
   endfunction

   // Offers one request, waits until it is taken, then paces the sender in bursts.
   task automatic send_timer_request(timer_req_type r);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r.mode, r.tag, r.arg, r.id, r.delay};
      req_tuser  <= r.rtype;
      cur_src    <= r.src;
      cur_beat   <= r.beat;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         // About one burst in eight runs long with no gap at all.
         burst_left = ($urandom_range(7) == 0) ? 40 : $urandom_range(1, 10);
         gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Both handshakes are sampled at the edge, so the request side is applied first.
   always @(posedge clock) begin
      timer_req_type  taken;
      timer_beat_type got;
      timer_beat_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            taken.rtype = req_tuser;
            taken.delay = req_tdata[31:0];
            taken.id    = req_tdata[39:32];
            taken.arg   = req_tdata[71:40];
            taken.tag   = req_tdata[103:72];
            taken.mode  = req_tdata[105:104];
            predict_timer_request(taken);
            if (cur_src == ANS_MODEL) begin
               foreach (step_beats[i]) awaited_beats.push_back(step_beats[i]);
            end else if (cur_src == ANS_TYPED) begin
               awaited_beats.push_back(cur_beat);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind    = detu_pkg::result_kind_type'(rsp_tuser);
            got.evt     = rsp_tdata[7:0];
            got.arg     = rsp_tdata[39:8];
            got.tag     = rsp_tdata[71:40];
            got.removed = rsp_tdata[76:72];
            got.last    = rsp_tlast;
            if (rsp_tuser <= detu_pkg::KIND_BADMODE) kind_hits[rsp_tuser]++;
            if (awaited_beats.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result beat, expected none, actual %s",
                        $time, beat_text(got));
            end else begin
               want = awaited_beats.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: result mismatch, expected %s, actual %s",
                           $time, beat_text(want), beat_text(got));
               end
            end
         end
      end
   end

   // Receiver: stretches of steady stall patterns, and one long hold once armed.
   initial begin
      int stretch;
      int stall_pct;
      forever begin
         stretch = $urandom_range(8, 60);
         case ($urandom_range(3))
            0, 1: stall_pct = 0;
            2: stall_pct = 40;
            default: stall_pct = 80;
         endcase
         repeat (stretch) begin
            @(posedge clock);
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
         if (hold_armed && !hold_done) begin
            @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      timer_req_type r;
      int            counted;
      int            ignored;
      int            next_profile;
      int            sched_pct;
      int            always_pct;
      int            id_span;
      int            pick;
      logic [1:0]    rtype;
      logic [31:0]   delay;
      logic [7:0]    id;
      logic [1:0]    mode;

      // Empty table first: a quiet tick, an unknown request, a delete that frees nothing.
      directed_rows.push_back(timer_row(detu_pkg::REQ_TICK, 32'd1, 8'd0, '0, '0,
                                        detu_pkg::MODE_ALWAYS, ANS_NONE));
      directed_rows.push_back(timer_row(REQ_UNKNOWN, 32'd0, 8'hFF, '1, '1,
                                        detu_pkg::MODE_INVALID, ANS_NONE));
      directed_rows.push_back(timer_row(detu_pkg::REQ_DELETE, 32'd7, 8'd0, '0, '0,
                                        detu_pkg::MODE_ALWAYS, ANS_TYPED,
                                        detu_pkg::KIND_DELETED, 0));
      // A zero delay fires at once even with the invalid mode.
      directed_rows.push_back(timer_row(detu_pkg::REQ_SCHED, 32'd0, 8'hFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, detu_pkg::MODE_INVALID, ANS_TYPED,
                                        detu_pkg::KIND_FIRED));
      directed_rows.push_back(timer_row(detu_pkg::REQ_SCHED, 32'd5, 8'h3C, 32'h0000_0001,
                                        32'h8000_0000, detu_pkg::MODE_INVALID, ANS_TYPED,
                                        detu_pkg::KIND_BADMODE));
      // Slot 0 holds the longest delay and never expires during the run.
      directed_rows.push_back(timer_row(detu_pkg::REQ_SCHED, 32'hFFFF_FFFF, 8'd0, '0, '0,
                                        detu_pkg::MODE_ALWAYS, ANS_TYPED,
                                        detu_pkg::KIND_SCHED, 0));
      for (int k = 1; k < SLOTS - 1; k++) begin
         directed_rows.push_back(timer_row(detu_pkg::REQ_SCHED, 32'd1, 8'(8'h40 + k),
                                           k * 32'h0101_0101, ~(k * 32'h0101_0101),
                                           detu_pkg::MODE_ALWAYS, ANS_MODEL));
      end
      directed_rows.push_back(timer_row(detu_pkg::REQ_SCHED, 32'd4, 8'h07, 32'hA5A5_5A5A,
                                        32'h0F0F_F0F0, detu_pkg::MODE_ALWAYS, ANS_MODEL));
      // The table is full now; the full check comes before delay and mode.
      directed_rows.push_back(timer_row(detu_pkg::REQ_SCHED, 32'd9, 8'h7E, 32'h1234_5678,
                                        32'h8765_4321, detu_pkg::MODE_COVER, ANS_TYPED,
                                        detu_pkg::KIND_FULL));
      // Fourteen slots fire on one tick; event 7 keeps three ticks to go.
      directed_rows.push_back(timer_row(detu_pkg::REQ_TICK, 32'd0, 8'd0, '0, '0,
                                        detu_pkg::MODE_ALWAYS, ANS_MODEL));
      directed_rows.push_back(timer_row(detu_pkg::REQ_SCHED, 32'd10, 8'h07, 32'h0000_FFFF,
                                        32'hFFFF_0000, detu_pkg::MODE_NEAREST, ANS_MODEL));
      directed_rows.push_back(timer_row(detu_pkg::REQ_SCHED, 32'd5, 8'h07, 32'h5555_AAAA,
                                        32'hAAAA_5555, detu_pkg::MODE_COVER, ANS_MODEL));
      directed_rows.push_back(timer_row(detu_pkg::REQ_DELETE, 32'd0, 8'd0, '0, '0,
                                        detu_pkg::MODE_ALWAYS, ANS_TYPED,
                                        detu_pkg::KIND_DELETED, 1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_timer_request(directed_rows[i]);

      counted      = 0;
      ignored      = 0;
      next_profile = 0;
      sched_pct    = 50;
      always_pct   = 35;
      id_span      = 3;
      while (counted < RANDOM_ITEMS) begin
         // Every 40 counted requests the mix changes; heavy plain scheduling fills the table.
         if (counted == next_profile) begin
            next_profile += 40;
            sched_pct  = ($urandom_range(2) == 0) ? 85 : $urandom_range(30, 60);
            always_pct = ($urandom_range(1) == 0) ? 85 : 35;
            id_span    = ($urandom_range(1) == 0) ? 3 : 31;
         end
         id = ($urandom_range(99) < 80) ? 8'($urandom_range(id_span)) :
                                          8'($urandom_range(255));
         pick = $urandom_range(99);
         if (pick < 8) begin
            delay = 32'd0;
         end else if (pick < 78) begin
            delay = $urandom_range(1, 6);
         end else if (pick < 92) begin
            delay = $urandom_range(7, 40);
         end else begin
            // Long waits stay on the few event ids that deletes keep clearing.
            delay = (pick < 97) ? $urandom : 32'hFFFF_FFFF;
            id    = 8'($urandom_range(3));
         end
         pick = $urandom_range(99);
         if (pick < always_pct) begin
            mode = detu_pkg::MODE_ALWAYS;
         end else begin
            pick = $urandom_range(99);
            if (pick < 45) mode = detu_pkg::MODE_COVER;
            else if (pick < 88) mode = detu_pkg::MODE_NEAREST;
            else mode = detu_pkg::MODE_INVALID;
         end
         pick = $urandom_range(99);
         if (pick < 3) rtype = REQ_UNKNOWN;
         else if (pick < sched_pct) rtype = detu_pkg::REQ_SCHED;
         else if (pick < sched_pct + (100 - sched_pct) / 3) rtype = detu_pkg::REQ_DELETE;
         else rtype = detu_pkg::REQ_TICK;

         r = timer_row(rtype, delay, id, $urandom, $urandom, mode, ANS_MODEL);
         send_timer_request(r);
         if (rtype == REQ_UNKNOWN) begin
            ignored++;
         end else begin
            counted++;
         end
         if (counted == 60) hold_armed = 1'b1;
      end
      req_tvalid <= 1'b0;

      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d directed and %0d random requests, %0d of them of unknown kind.",
               directed_rows.size(), counted + ignored, ignored);
      $display("Result beats seen: %0d fired, %0d scheduled, %0d deleted, %0d full, %0d bad mode.",
               kind_hits[detu_pkg::KIND_FIRED], kind_hits[detu_pkg::KIND_SCHED],
               kind_hits[detu_pkg::KIND_DELETED], kind_hits[detu_pkg::KIND_FULL],
               kind_hits[detu_pkg::KIND_BADMODE]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
